>>> hw/rtl/cdnc_pkg.sv
package cdnc_pkg;

    localparam logic [11:0] FIRST_YEAR      = 12'd1970;
    localparam logic [11:0] LAST_YEAR       = 12'd2099;
    localparam logic [15:0] LAST_DAY_NUMBER = 16'd47481;
    localparam logic [3:0]  FIRST_MONTH     = 4'd1;
    localparam logic [3:0]  LAST_MONTH      = 4'd12;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_YEAR  = 3'd1;
    localparam logic [2:0] ERR_MONTH = 3'd2;
    localparam logic [2:0] ERR_DAY   = 3'd3;
    localparam logic [2:0] ERR_RANGE = 3'd4;

    typedef struct packed {
        logic        sub;
        logic [15:0] a;
        logic [15:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] sum;
        logic        carry;
    } alu_rsp_t;

    typedef struct packed {
        logic [15:0] day_number;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  err;
    } result_t;

    // covers 1970..2099 only, where every fourth year is a leap year
    function automatic logic leap(input logic [11:0] y);
        leap = (y[1:0] == 2'b00);
    endfunction

    function automatic logic [8:0] year_len(input logic [11:0] y);
        year_len = leap(y) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = lp ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        month_len = len;
    endfunction

endpackage

>>> hw/rtl/calendar_day_number_converter_core.sv
// a rejected transaction goes from acceptance straight to S_DONE and then into
// the output register; a valid one first steps through S_YEAR, one step per year
// from 1970, and S_MONTH, one step per month up to the target, then S_DAY for
// date to number only, then S_DONE and the output register, all on one shared
// adder; one transaction at a time: in_stall is high until the result moves into
// the output register, which holds it while out_stall is high
// reset: asynchronous active-low rst_n idles the sequencer and clears out_valid
module calendar_day_number_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [4:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [11:0] year_in,
    input  logic [15:0] day_number_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] day_number_out,
    output logic [4:0]  day_out,
    output logic [3:0]  month_out,
    output logic [11:0] year_out,
    output logic [2:0]  error_code
);
    import cdnc_pkg::*;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    result_t  result;
    logic     done;
    logic     out_free;
    logic     out_valid_reg, out_valid_next;
    result_t  out_reg, out_next;

    cdnc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    cdnc_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .day_in        (day_in),
        .month_in      (month_in),
        .year_in       (year_in),
        .day_number_in (day_number_in),
        .alu_req       (alu_req),
        .alu_rsp       (alu_rsp),
        .done          (done),
        .out_free      (out_free),
        .result        (result)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free)
        begin
            out_valid_next = done;
            if (done)
                out_next = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign day_number_out = out_reg.day_number;
    assign day_out        = out_reg.day;
    assign month_out      = out_reg.month;
    assign year_out       = out_reg.year;
    assign error_code     = out_reg.err;

endmodule

>>> hw/rtl/cdnc_alu.sv
module cdnc_alu (
    input  cdnc_pkg::alu_req_t req,
    output cdnc_pkg::alu_rsp_t rsp
);
    import cdnc_pkg::*;

    logic [15:0] b_eff;
    logic [16:0] total;

    // carry out on subtract means a >= b
    assign b_eff   = req.sub ? ~req.b : req.b;
    assign total   = {1'b0, req.a} + {1'b0, b_eff} + {16'd0, req.sub};
    assign rsp.sum   = total[15:0];
    assign rsp.carry = total[16];

endmodule

>>> hw/rtl/cdnc_seq.sv
module cdnc_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [4:0]         day_in,
    input  logic [3:0]         month_in,
    input  logic [11:0]        year_in,
    input  logic [15:0]        day_number_in,
    output cdnc_pkg::alu_req_t alu_req,
    input  cdnc_pkg::alu_rsp_t alu_rsp,
    output logic               done,
    input  logic               out_free,
    output cdnc_pkg::result_t  result
);
    import cdnc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_YEAR  = 3'd1;
    localparam logic [2:0] S_MONTH = 3'd2;
    localparam logic [2:0] S_DAY   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        opcode_reg, opcode_next;
    logic [2:0]  err_reg, err_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] num_reg, num_next;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [11:0] year_reg, year_next;
    logic [11:0] ycnt_reg, ycnt_next;
    logic [3:0]  mcnt_reg, mcnt_next;

    logic        accept;
    logic [2:0]  in_err;
    logic [11:0] leap_year_sel;
    logic        take_year;
    logic        take_month;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign done     = (state_reg == S_DONE);

    always_comb
    begin
        in_err = ERR_NONE;
        if (opcode)
        begin
            if (day_number_in > LAST_DAY_NUMBER)
                in_err = ERR_RANGE;
        end
        else
        begin
            priority if (year_in < FIRST_YEAR || year_in > LAST_YEAR)
                in_err = ERR_YEAR;
            else if (month_in < FIRST_MONTH || month_in > LAST_MONTH)
                in_err = ERR_MONTH;
            else if (day_in == 5'd0 || day_in > month_len(month_in, leap(year_in)))
                in_err = ERR_DAY;
            else
                in_err = ERR_NONE;
        end
    end

    assign leap_year_sel = opcode_reg ? ycnt_reg : year_reg;

    always_comb
    begin
        alu_req.sub = opcode_reg;
        alu_req.a   = acc_reg;
        unique case (state_reg)
            S_YEAR:  alu_req.b = {7'd0, year_len(ycnt_reg)};
            S_MONTH: alu_req.b = {11'd0, month_len(mcnt_reg, leap(leap_year_sel))};
            default: alu_req.b = {11'd0, day_reg - 5'd1};
        endcase
    end

    assign take_year  = opcode_reg ? (ycnt_reg < LAST_YEAR && alu_rsp.carry)
                                   : (ycnt_reg < year_reg);
    assign take_month = opcode_reg ? (mcnt_reg < LAST_MONTH && alu_rsp.carry)
                                   : (mcnt_reg < month_reg);

    always_comb
    begin
        state_next  = state_reg;
        opcode_next = opcode_reg;
        err_next    = err_reg;
        acc_next    = acc_reg;
        num_next    = num_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        ycnt_next   = ycnt_reg;
        mcnt_next   = mcnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    opcode_next = opcode;
                    err_next    = in_err;
                    num_next    = day_number_in;
                    day_next    = day_in;
                    month_next  = month_in;
                    year_next   = year_in;
                    ycnt_next   = FIRST_YEAR;
                    acc_next    = opcode ? day_number_in : 16'd0;
                    state_next  = (in_err != ERR_NONE) ? S_DONE : S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (take_year)
                begin
                    acc_next  = alu_rsp.sum;
                    ycnt_next = ycnt_reg + 12'd1;
                end
                else
                begin
                    mcnt_next  = FIRST_MONTH;
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (take_month)
                begin
                    acc_next  = alu_rsp.sum;
                    mcnt_next = mcnt_reg + 4'd1;
                end
                else if (opcode_reg)
                begin
                    day_next   = acc_reg[4:0] + 5'd1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DAY;
                end
            end
            S_DAY:
            begin
                acc_next   = alu_rsp.sum;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result = '0;
        result.err = err_reg;
        if (err_reg == ERR_NONE)
        begin
            result.day = day_reg;
            if (opcode_reg)
            begin
                result.day_number = num_reg;
                result.month      = mcnt_reg;
                result.year       = ycnt_reg;
            end
            else
            begin
                result.day_number = acc_reg;
                result.month      = month_reg;
                result.year       = year_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        opcode_reg <= opcode_next;
        err_reg    <= err_next;
        acc_reg    <= acc_next;
        num_reg    <= num_next;
        day_reg    <= day_next;
        month_reg  <= month_next;
        year_reg   <= year_next;
        ycnt_reg   <= ycnt_next;
        mcnt_reg   <= mcnt_next;
    end

    a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YEAR || state_reg == S_MONTH) |-> ycnt_reg <= LAST_YEAR)
        else $error("year counter past last year");

    a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MONTH |-> (mcnt_reg >= FIRST_MONTH && mcnt_reg <= LAST_MONTH))
        else $error("month counter out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.err != ERR_NONE) |->
            (result.day_number == 16'd0 && result.day == 5'd0 &&
             result.month == 4'd0 && result.year == 12'd0))
        else $error("error result carries nonzero fields");

    a_decode_day: assert property (@(posedge clk) disable iff (!rst_n)
        (done && opcode_reg && err_reg == ERR_NONE) |->
            (result.day != 5'd0 && result.month != 4'd0))
        else $error("decoded date has zero day or month");

endmodule

>>> verif/tb.sv
module tb;
    import cdnc_pkg::*;

    localparam logic OP_DATE_TO_NUM = 1'b0;
    localparam logic OP_NUM_TO_DATE = 1'b1;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   DRAIN_CYCLES   = 200;
    localparam int   RANDOM_ITEMS   = 1826;

    typedef struct packed {
        logic        op;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [15:0] number;
    } conv_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = 1'b0;
    logic [4:0]  day_in = '0;
    logic [3:0]  month_in = '0;
    logic [11:0] year_in = '0;
    logic [15:0] day_number_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] day_number_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [11:0] year_out;
    logic [2:0]  error_code;

    conv_req_t pending_conversions[$];
    result_t   conversion_results[$];
    conv_req_t next_req;
    conv_req_t seen_req;
    result_t   want;

    logic in_taken = 1'b0;
    logic quiet = 1'b0;
    int   in_gap = 0;
    int   out_run = 0;
    int   in_count = 0;
    int   idle_cycles = 0;
    int   errors = 0;
    int   total = 0;
    bit   timed_out = 1'b0;

    calendar_day_number_converter_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .day_in         (day_in),
        .month_in       (month_in),
        .year_in        (year_in),
        .day_number_in  (day_number_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .day_number_out (day_number_out),
        .day_out        (day_out),
        .month_out      (month_out),
        .year_out       (year_out),
        .error_code     (error_code)
    );

    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned days_in_year(input int unsigned y);
        return is_leap(y) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        case (m)
            2:            return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    function automatic result_t convert_calendar(input conv_req_t t);
        result_t     r;
        int unsigned n;
        int unsigned y;
        int unsigned m;
        logic [2:0]  err;
        r = '0;
        err = ERR_NONE;
        if (t.op == OP_DATE_TO_NUM) begin
            if (t.year < FIRST_YEAR || t.year > LAST_YEAR)
                err = ERR_YEAR;
            else if (t.month < FIRST_MONTH || t.month > LAST_MONTH)
                err = ERR_MONTH;
            else if (t.day == 0 || t.day > days_in_month(t.month, t.year))
                err = ERR_DAY;
            if (err == ERR_NONE) begin
                n = 0;
                for (y = FIRST_YEAR; y < t.year; y++)
                    n += days_in_year(y);
                for (m = 1; m < t.month; m++)
                    n += days_in_month(m, t.year);
                n += t.day - 1;
                r.day_number = n[15:0];
                r.day = t.day;
                r.month = t.month;
                r.year = t.year;
            end
        end else if (t.number > LAST_DAY_NUMBER) begin
            err = ERR_RANGE;
        end else begin
            n = t.number;
            y = FIRST_YEAR;
            while (y < LAST_YEAR && days_in_year(y) <= n) begin
                n -= days_in_year(y);
                y++;
            end
            m = 1;
            while (m < 12 && days_in_month(m, y) <= n) begin
                n -= days_in_month(m, y);
                m++;
            end
            r.day_number = t.number;
            r.day = 5'(n + 1);
            r.month = 4'(m);
            r.year = 12'(y);
        end
        r.err = err;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_date(input int d, input int m, input int y);
        conv_req_t t;
        t.op = OP_DATE_TO_NUM;
        t.day = d[4:0];
        t.month = m[3:0];
        t.year = y[11:0];
        t.number = 16'($urandom);
        pending_conversions.push_back(t);
    endtask

    task automatic add_number(input int n);
        conv_req_t t;
        t.op = OP_NUM_TO_DATE;
        t.day = 5'($urandom);
        t.month = 4'($urandom);
        t.year = 12'($urandom);
        t.number = n[15:0];
        pending_conversions.push_back(t);
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch %s: got %0d, expected %0d", what, got, exp_val);
        errors++;
    endtask

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // input driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_taken) begin
        end else if (in_gap > 0) begin
            in_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (pending_conversions.size() > 0) begin
            next_req = pending_conversions.pop_front();
            in_valid <= 1'b1;
            opcode <= next_req.op;
            day_in <= next_req.day;
            month_in <= next_req.month;
            year_in <= next_req.year;
            day_number_in <= next_req.number;
            in_gap <= pick_gap();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // output back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (out_run > 0) begin
            out_run <= out_run - 1;
        end else begin
            out_stall <= !quiet && ($urandom_range(0, 1) == 1);
            out_run <= pick_gap();
        end
    end

    // monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_valid && !in_stall;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && !in_stall) begin
                seen_req.op = opcode;
                seen_req.day = day_in;
                seen_req.month = month_in;
                seen_req.year = year_in;
                seen_req.number = day_number_in;
                conversion_results.push_back(convert_calendar(seen_req));
                in_count <= in_count + 1;
                if (in_count % 150 == 149)
                    quiet <= ($urandom_range(0, 3) == 0);
            end
            if (out_valid && !out_stall) begin
                if (conversion_results.size() == 0) begin
                    report_mismatch("transaction with none pending, error_code", error_code, 0);
                end else begin
                    want = conversion_results.pop_front();
                    if (day_number_out !== want.day_number)
                        report_mismatch("day_number_out", day_number_out, want.day_number);
                    if (day_out !== want.day)
                        report_mismatch("day_out", day_out, want.day);
                    if (month_out !== want.month)
                        report_mismatch("month_out", month_out, want.month);
                    if (year_out !== want.year)
                        report_mismatch("year_out", year_out, want.year);
                    if (error_code !== want.err)
                        report_mismatch("error_code", error_code, want.err);
                end
            end
        end
    end

    initial begin
        int        kind;
        int        y;
        int        m;
        int        d;
        int        n;
        conv_req_t probe;
        result_t   probe_res;

        add_date(1, 1, 1970);
        add_date(31, 12, 2099);
        add_date(1, 1, 1969);
        add_date(1, 1, 2100);
        add_date(1, 1, 0);
        add_date(31, 15, 4095);
        add_date(1, 0, 2000);
        add_date(1, 13, 2000);
        add_date(0, 5, 1990);
        add_date(29, 2, 2000);
        add_date(29, 2, 2024);
        add_date(29, 2, 2023);
        add_date(30, 2, 2096);
        add_date(31, 4, 2010);
        add_date(30, 4, 2010);
        add_date(31, 12, 1972);
        add_number(0);
        add_number(LAST_DAY_NUMBER);
        add_number(LAST_DAY_NUMBER + 1);
        add_number(65535);
        add_number(365);
        add_number(789);
        add_number(790);
        add_number(10956);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(0, 99);
            y = $urandom_range(FIRST_YEAR, LAST_YEAR);
            m = $urandom_range(1, 12);
            if (kind < 40) begin
                add_date($urandom_range(1, days_in_month(m, y)), m, y);
            end else if (kind < 45) begin
                d = days_in_month(m, y);
                case ($urandom_range(0, 2))
                    0:       add_date(0, m, y);
                    1:       add_date(d, m, y);
                    default: add_date(d + 1, m, y);
                endcase
            end else if (kind < 70) begin
                add_number($urandom_range(0, LAST_DAY_NUMBER));
            end else if (kind < 80) begin
                // land on or just before a month start
                probe.op = OP_DATE_TO_NUM;
                probe.day = 5'd1;
                probe.month = m[3:0];
                probe.year = y[11:0];
                probe.number = '0;
                probe_res = convert_calendar(probe);
                n = probe_res.day_number;
                if (n > 0)
                    n = n - $urandom_range(0, 1);
                add_number(n);
            end else if (kind < 90) begin
                if ($urandom_range(0, 1) == 1)
                    add_number($urandom_range(0, 65535));
                else
                    add_date($urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, 4095));
            end else if (kind < 95) begin
                add_number($urandom_range(LAST_DAY_NUMBER + 1, 65535));
            end else if ($urandom_range(0, 1) == 1) begin
                add_date($urandom_range(1, 28),
                         ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(13, 15), y);
            end else begin
                add_date($urandom_range(1, 28), m,
                         ($urandom_range(0, 1) == 1) ? $urandom_range(0, FIRST_YEAR - 1)
                                                     : $urandom_range(LAST_YEAR + 1, 4095));
            end
        end
        total = pending_conversions.size();

        wait (rst_n === 1'b1);
        while (!(in_count == total && conversion_results.size() == 0)
               && idle_cycles < WATCHDOG_LIMIT)
            @(negedge clk);
        timed_out = (idle_cycles >= WATCHDOG_LIMIT);
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(negedge clk);
        if (conversion_results.size() != 0)
            report_mismatch("transactions never produced", conversion_results.size(), 0);
        if (!timed_out && errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> calendar_day_number_converter_core.f
hw/rtl/cdnc_pkg.sv
hw/rtl/cdnc_alu.sv
hw/rtl/cdnc_seq.sv
hw/rtl/calendar_day_number_converter_core.sv
verif/tb.sv
